// File: sv/plwd_pkg.sv
// Package for the position lock window detector: widths, reset values,
// register indexes, the per-tick sample type and the anchor count helper.
// No dependencies.
package plwd_pkg;

  localparam int unsigned WINDOW_DEFAULT       = 50;
  localparam int unsigned ANCHOR_SLOTS_DEFAULT = 8;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned AXES       = 3;
  localparam int unsigned MASK_W     = 8;
  localparam int unsigned ANCHORS_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SAMPLE_W-1:0]  SPREAD_LIMIT_RESET = 32'd16777;
  localparam logic [ANCHORS_W-1:0] MIN_ANCHORS_RESET  = 4'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANCHORS  = 2'd1;

  // One variance sample per axis: [0] = x, [1] = y, [2] = z.
  typedef logic [AXES-1:0][SAMPLE_W-1:0] axes_t;

  // Control from the sequencer to the min/max unit.
  typedef struct packed {
    logic clear;
    logic update;
  } minmax_ctl_t;

  // Set bits among the first slots positions of the mask.
  function automatic logic [ANCHORS_W-1:0] count_anchors(logic [MASK_W-1:0] mask,
                                                         int unsigned slots);
    logic [ANCHORS_W-1:0] n;
    n = '0;
    for (int unsigned i = 0; i < MASK_W; i++) begin
      if (i < slots) begin
        n = n + ANCHORS_W'(mask[i]);
      end
    end
    return n;
  endfunction

endpackage

// File: sv/plwd_if.sv
// Channel interfaces of the position lock window detector: sample beats in,
// lock result beats out. Depends on plwd_pkg.
interface plwd_in_if;
  logic                          valid;
  logic                          ready;
  logic [plwd_pkg::SAMPLE_W-1:0] var_x;
  logic [plwd_pkg::SAMPLE_W-1:0] var_y;
  logic [plwd_pkg::SAMPLE_W-1:0] var_z;
  logic [plwd_pkg::MASK_W-1:0]   anchor_mask;
  logic                          sensors_calibrated;

  modport source (output valid, var_x, var_y, var_z, anchor_mask, sensors_calibrated,
                  input ready);
  modport sink (input valid, var_x, var_y, var_z, anchor_mask, sensors_calibrated,
                output ready);
endinterface

interface plwd_out_if;
  logic valid;
  logic ready;
  logic locked;

  modport source (output valid, locked, input ready);
  modport sink (input valid, locked, output ready);
endinterface

// File: sv/plwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plwd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/plwd_minmax.sv
// Shared min/max unit: folds one window entry per cycle into running
// per-axis extremes and reports whether every spread is under threshold.
// Depends on plwd_pkg.
module plwd_minmax (
  input  logic                          clk,
  input  plwd_pkg::minmax_ctl_t         ctl,
  input  plwd_pkg::axes_t               sample,
  input  logic [plwd_pkg::SAMPLE_W-1:0] threshold,
  output logic                          spread_ok
);

  plwd_pkg::axes_t lo;
  plwd_pkg::axes_t hi;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      lo <= '1;
      hi <= '0;
    end else if (ctl.update) begin
      for (int a = 0; a < plwd_pkg::AXES; a++) begin
        if (sample[a] < lo[a]) begin
          lo[a] <= sample[a];
        end
        if (sample[a] > hi[a]) begin
          hi[a] <= sample[a];
        end
      end
    end
  end

  // Strictly below: a spread equal to the threshold fails.
  always_comb begin
    spread_ok = 1'b1;
    for (int a = 0; a < plwd_pkg::AXES; a++) begin
      if ((hi[a] - lo[a]) >= threshold) begin
        spread_ok = 1'b0;
      end
    end
  end

endmodule

// File: sv/position_lock_window_detector.sv
// Position lock window detector, top level. While the window fills, an accepted
// beat goes straight to the result; once it is full, every entry is scanned
// through the single RAM read port before the result is ready. A new beat is
// taken only after the result is loaded into the output register.
// Reset (rst, synchronous, active high): ring empty, write slot 0, registers
// back to threshold 16777 and four anchors; no clearing pass, RAM untouched.
module position_lock_window_detector #(
  parameter int unsigned WINDOW       = plwd_pkg::WINDOW_DEFAULT,
  parameter int unsigned ANCHOR_SLOTS = plwd_pkg::ANCHOR_SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  plwd_in_if.sink                         sample_ch,
  plwd_out_if.source                      result_ch,
  input  logic                            cfg_write,
  input  logic [plwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plwd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam int unsigned RAM_W  = plwd_pkg::AXES * plwd_pkg::SAMPLE_W;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a sample beat
  localparam logic [1:0] ST_SCAN = 2'd1;  // issuing one RAM read per cycle
  localparam logic [1:0] ST_LAST = 2'd2;  // last read data folding in
  localparam logic [1:0] ST_DONE = 2'd3;  // result waits for the output register

  logic [1:0]                       state;
  logic [SLOT_W-1:0]                slot;
  logic [FILL_W-1:0]                filled;
  logic [FILL_W-1:0]                filled_next;
  logic [SLOT_W-1:0]                rd_addr;
  logic                             rd_valid;
  logic                             anchors_ok;
  logic                             calibrated;
  logic                             out_valid;
  logic                             out_locked;
  logic [plwd_pkg::SAMPLE_W-1:0]    spread_limit;
  logic [plwd_pkg::ANCHORS_W-1:0]   min_anchors;

  logic                             accept;
  logic                             out_load;
  logic                             window_full;
  logic                             spread_ok;
  plwd_pkg::axes_t                  wr_sample;
  logic [RAM_W-1:0]                 rd_data;
  plwd_pkg::minmax_ctl_t            mm_ctl;

  assign sample_ch.ready = (state == ST_IDLE);
  assign accept          = sample_ch.valid && sample_ch.ready;

  // Fill count saturates at the window length.
  assign filled_next = (filled == FILL_W'(WINDOW)) ? filled : filled + FILL_W'(1);
  assign window_full = (filled == FILL_W'(WINDOW));

  // Output register: a finished result parks here while the next beat is taken.
  assign out_load         = (state == ST_DONE) && (!out_valid || result_ch.ready);
  assign result_ch.valid  = out_valid;
  assign result_ch.locked = out_locked;

  // Configuration registers; writes beyond the list fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      spread_limit <= plwd_pkg::SPREAD_LIMIT_RESET;
      min_anchors  <= plwd_pkg::MIN_ANCHORS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        plwd_pkg::REG_SPREAD_LIMIT: spread_limit <= cfg_data;
        plwd_pkg::REG_MIN_ANCHORS:  min_anchors <= cfg_data[plwd_pkg::ANCHORS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      slot     <= '0;
      filled   <= '0;
      rd_addr  <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            slot    <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
            filled  <= filled_next;
            rd_addr <= '0;
            // Only a full window is scanned, so unwritten entries are never read.
            state   <= (filled_next == FILL_W'(WINDOW)) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          rd_addr <= rd_addr + SLOT_W'(1);
          if (rd_addr == SLOT_W'(WINDOW - 1)) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-beat side conditions, captured at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      anchors_ok <= plwd_pkg::count_anchors(sample_ch.anchor_mask, ANCHOR_SLOTS)
                    >= min_anchors;
      calibrated <= sample_ch.sensors_calibrated;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_locked <= window_full && spread_ok && calibrated && anchors_ok;
    end
  end

  // History ring, all three axes side by side in one RAM word.
  assign wr_sample[0] = sample_ch.var_x;
  assign wr_sample[1] = sample_ch.var_y;
  assign wr_sample[2] = sample_ch.var_z;

  plwd_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW)
  ) u_history (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (RAM_W'(wr_sample)),
    .re    (state == ST_SCAN),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Extremes restart with each beat; each read word folds in the cycle after its read.
  assign mm_ctl.clear  = accept;
  assign mm_ctl.update = rd_valid;

  plwd_minmax u_minmax (
    .clk       (clk),
    .ctl       (mm_ctl),
    .sample    (plwd_pkg::axes_t'(rd_data)),
    .threshold (spread_limit),
    .spread_ok (spread_ok)
  );

endmodule

// File: sv/plwd_checker.sv
// Port-level checker for the position lock window detector, with its bind.
// Depends on plwd_pkg and position_lock_window_detector.
module plwd_checker #(
  parameter int unsigned WINDOW = plwd_pkg::WINDOW_DEFAULT
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_locked,
  input logic                            cfg_write,
  input logic [plwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [plwd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  logic [CNT_W-1:0]              seen;
  logic [plwd_pkg::SAMPLE_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (in_valid && in_ready && (seen != CNT_W'(WINDOW))) begin
      seen <= seen + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= plwd_pkg::SPREAD_LIMIT_RESET;
    end else if (cfg_write && (cfg_index == plwd_pkg::REG_SPREAD_LIMIT)) begin
      thr <= cfg_data;
    end
  end

  // One beat at a time: busy right after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in flight");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_locked))
    else $error("stalled result changed or dropped");

  a_no_lock_before_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_locked |-> seen == CNT_W'(WINDOW))
    else $error("lock reported before window filled");

  a_no_lock_zero_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_locked |-> thr != '0)
    else $error("lock reported with zero threshold");

endmodule

bind position_lock_window_detector plwd_checker #(
  .WINDOW (WINDOW)
) u_plwd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample_ch.valid),
  .in_ready   (sample_ch.ready),
  .out_valid  (result_ch.valid),
  .out_ready  (result_ch.ready),
  .out_locked (result_ch.locked),
  .cfg_write  (cfg_write),
  .cfg_index  (cfg_index),
  .cfg_data   (cfg_data)
);
